@@ rtl/phtc_pkg.sv @@
// Package: shared constants, codes and the queued item type of the host traffic table.
`timescale 1ns / 1ps
package phtc_pkg;
  localparam int BUCKETS = 256;
  localparam int WAYS_DEFAULT = 4;
  localparam int COUNT_WIDTH_DEFAULT = 64;

  localparam logic OP_ACCOUNT = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] frame_length;
    logic [9:0]  slot_index;
    logic [9:0]  rd_quot;
    logic        oor;
  } item_t;
endpackage

@@ rtl/phtc_front.sv @@
// Front end: accepts items, derives a read slot index's bucket and range flag, queues them.
`timescale 1ns / 1ps
module phtc_front #(
  parameter int WAYS = phtc_pkg::WAYS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                operation,
  input  logic [31:0]         src_addr,
  input  logic [31:0]         dst_addr,
  input  logic [15:0]         frame_length,
  input  logic [9:0]          slot_index,
  input  logic                hold,
  output logic                q_valid,
  output phtc_pkg::item_t     q_item,
  input  logic                q_pop
);
  localparam int RECIP_SH = 24;
  localparam int RECIP = ((1 << RECIP_SH) + WAYS - 1) / WAYS;
  localparam int TOTAL = phtc_pkg::BUCKETS * WAYS;

  phtc_pkg::item_t fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic [35:0] prod;
  phtc_pkg::item_t item;

  assign full = (count == 2'd2) || hold;
  assign accept = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item = fifo[rd_ptr];

  always_comb begin
    prod = 36'(slot_index) * 36'(RECIP);
    item.operation = operation;
    item.src_addr = src_addr;
    item.dst_addr = dst_addr;
    item.frame_length = frame_length;
    item.slot_index = slot_index;
    item.rd_quot = prod[RECIP_SH +: 10];
    item.oor = (32'(slot_index) >= TOTAL);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fifo[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(accept) - 2'(q_pop && q_valid);
    end
  end
endmodule

@@ rtl/phtc_back.sv @@
// Back end: bucket lookup, entry insertion, saturating counter updates, slot reads.
`timescale 1ns / 1ps
module phtc_back #(
  parameter int WAYS = phtc_pkg::WAYS_DEFAULT,
  parameter int COUNT_WIDTH = phtc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  phtc_pkg::item_t        q_item,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   res_valid,
  input  logic                   pop,
  output logic                   entry_valid,
  output logic [31:0]            entry_addr,
  output logic [COUNT_WIDTH-1:0] sent_cnt,
  output logic [COUNT_WIDTH-1:0] recv_cnt,
  output logic                   src_dropped,
  output logic                   dst_dropped
);
  localparam int SLOTS = phtc_pkg::BUCKETS * WAYS;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W = $clog2(WAYS + 1);
  localparam int CW = COUNT_WIDTH;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [FILL_W-1:0]    fill_mem [phtc_pkg::BUCKETS];
  logic [WAYS*32-1:0]   host_mem [phtc_pkg::BUCKETS];
  logic [CW-1:0]        sent_mem [SLOTS];
  logic [CW-1:0]        recv_mem [SLOTS];
  logic [FILL_W-1:0]    fill_rd;
  logic [WAYS*32-1:0]   host_rd;
  logic [CW-1:0]        sent_rd;
  logic [CW-1:0]        recv_rd;

  logic [2:0]           st;
  logic [2:0]           st_next;
  logic [7:0]           clr_cnt;
  phtc_pkg::item_t      cur;
  logic                 side;
  logic                 drop_s;
  logic                 drop_d;
  logic [SLOT_W-1:0]    slot;

  logic [31:0]          host_cur;
  logic [7:0]           bkt;
  logic [WAYS-1:0]      hit;
  logic                 any_hit;
  logic [WAY_W-1:0]     hit_way;
  logic                 new_ok;
  logic [WAY_W-1:0]     sel_way;
  logic [SLOT_W-1:0]    sel_slot;
  logic                 tbl_re;
  logic                 fill_we;
  logic [7:0]           fill_wa;
  logic [FILL_W-1:0]    fill_wd;
  logic                 host_we;
  logic [WAYS*32-1:0]   host_wd;
  logic                 cnt_re;
  logic [SLOT_W-1:0]    cnt_ra;
  logic                 sent_we;
  logic                 recv_we;
  logic [SLOT_W-1:0]    cnt_wa;
  logic [CW-1:0]        sent_wd;
  logic [CW-1:0]        recv_wd;
  logic [CW:0]          sum;
  logic [CW-1:0]        sat;
  logic                 is_new;
  logic                 is_upd;
  logic [WAY_W-1:0]     rd_way;
  logic                 rd_valid;
  logic                 out_free;

  assign clearing = (st == ST_CLEAR);
  assign out_free = !res_valid || pop;
  assign host_cur = side ? cur.dst_addr : cur.src_addr;
  assign bkt = (cur.operation == phtc_pkg::OP_READ) ? cur.rd_quot[7:0] : host_cur[31:24];

  always_comb begin
    hit_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      hit[i] = (FILL_W'(i) < fill_rd) && (host_rd[i*32 +: 32] == host_cur);
      hit_way = hit_way | (hit[i] ? WAY_W'(i) : '0);
    end
    any_hit = |hit;
    new_ok = (fill_rd < FILL_W'(WAYS));
    sel_way = any_hit ? hit_way : fill_rd[WAY_W-1:0];
    sel_slot = SLOT_W'(SLOT_W'(bkt) * SLOT_W'(WAYS)) + SLOT_W'(sel_way);
    for (int i = 0; i < WAYS; i++) begin
      host_wd[i*32 +: 32] = (FILL_W'(i) == fill_rd) ? host_cur : host_rd[i*32 +: 32];
    end
    is_new = (st == ST_CMP) && !any_hit && new_ok;
    is_upd = (st == ST_UPD);
    sum = {1'b0, (side ? recv_rd : sent_rd)} + (CW+1)'(cur.frame_length);
    sat = sum[CW] ? '1 : sum[CW-1:0];

    tbl_re = (st == ST_LOOK);
    fill_we = clearing || is_new;
    fill_wa = clearing ? clr_cnt : bkt;
    fill_wd = clearing ? '0 : fill_rd + FILL_W'(1);
    host_we = is_new;
    cnt_re = ((st == ST_LOOK) && (cur.operation == phtc_pkg::OP_READ))
             || ((st == ST_CMP) && any_hit);
    cnt_ra = (st == ST_LOOK) ? SLOT_W'(cur.slot_index) : sel_slot;
    sent_we = is_new || (is_upd && !side);
    recv_we = is_new || (is_upd && side);
    cnt_wa = is_upd ? slot : sel_slot;
    sent_wd = is_upd ? sat : (side ? '0 : CW'(cur.frame_length));
    recv_wd = is_upd ? sat : (side ? CW'(cur.frame_length) : '0);

    rd_way = WAY_W'(cur.slot_index - 10'(cur.rd_quot * 10'(WAYS)));
    rd_valid = !cur.oor && (FILL_W'(rd_way) < fill_rd);
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    if (host_we) begin
      host_mem[bkt] <= host_wd;
    end
    if (tbl_re) begin
      fill_rd <= fill_mem[bkt];
      host_rd <= host_mem[bkt];
    end
  end

  always_ff @(posedge clk) begin
    if (sent_we) begin
      sent_mem[cnt_wa] <= sent_wd;
    end
    if (recv_we) begin
      recv_mem[cnt_wa] <= recv_wd;
    end
    if (cnt_re) begin
      sent_rd <= sent_mem[cnt_ra];
      recv_rd <= recv_mem[cnt_ra];
    end
  end

  always_comb begin
    st_next = st;
    q_pop = 1'b0;
    unique case (st)
      ST_CLEAR: if (clr_cnt == 8'hFF) st_next = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          st_next = ST_LOOK;
        end
      end
      ST_LOOK: st_next = (cur.operation == phtc_pkg::OP_READ) ? ST_RD : ST_CMP;
      ST_CMP: begin
        if (any_hit) st_next = ST_UPD;
        else st_next = side ? ST_FIN : ST_LOOK;
      end
      ST_UPD: st_next = side ? ST_FIN : ST_LOOK;
      ST_RD, ST_FIN: if (out_free) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if ((st == ST_CMP) && any_hit) begin
      slot <= sel_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_CLEAR;
      clr_cnt <= 8'd0;
      side <= 1'b0;
      drop_s <= 1'b0;
      drop_d <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 8'd1;
      end
      if (q_pop) begin
        side <= 1'b0;
        drop_s <= 1'b0;
        drop_d <= 1'b0;
      end
      if ((st == ST_CMP) && !any_hit && !new_ok) begin
        if (side) drop_d <= 1'b1;
        else drop_s <= 1'b1;
      end
      if (((st == ST_CMP) && !any_hit) || is_upd) begin
        side <= 1'b1;
      end
      if (pop) begin
        res_valid <= 1'b0;
      end
      if (((st == ST_RD) || (st == ST_FIN)) && out_free) begin
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((st == ST_RD) && out_free) begin
      entry_valid <= rd_valid;
      entry_addr <= rd_valid ? host_rd[rd_way*32 +: 32] : 32'd0;
      sent_cnt <= rd_valid ? sent_rd : '0;
      recv_cnt <= rd_valid ? recv_rd : '0;
      src_dropped <= 1'b0;
      dst_dropped <= 1'b0;
    end else if ((st == ST_FIN) && out_free) begin
      entry_valid <= 1'b0;
      entry_addr <= 32'd0;
      sent_cnt <= '0;
      recv_cnt <= '0;
      src_dropped <= drop_s;
      dst_dropped <= drop_d;
    end
  end
endmodule

@@ rtl/per_host_traffic_counter_table.sv @@
// Top level: per-host IPv4 byte accounting table with queue-style ports.
`timescale 1ns / 1ps
// Hosts hash to one of 256 buckets by the top address byte, each bucket holding WAYS
// entries filled from way 0 upward; a full bucket drops that host's update and flags it.
// Counters are COUNT_WIDTH bits and saturate. After reset a clearing pass over all 256
// buckets resets their fill counts, with full held high. The back end then handles an
// account item as lookup, compare and counter read-modify-write for the source and again
// for the destination, all through single-port table memories, and a read item as lookup
// and slot read. A two-entry queue in front lets new items in while the back end works.
module per_host_traffic_counter_table #(
  parameter int WAYS = phtc_pkg::WAYS_DEFAULT,
  parameter int COUNT_WIDTH = phtc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        operation,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] frame_length,
  input  logic [9:0]  slot_index,
  output logic        empty,
  input  logic        pop,
  output logic        entry_valid,
  output logic [31:0] entry_addr,
  output logic [63:0] sent_bytes,
  output logic [63:0] received_bytes,
  output logic        src_dropped,
  output logic        dst_dropped
);
  logic                   q_valid;
  phtc_pkg::item_t        q_item;
  logic                   q_pop;
  logic                   clearing;
  logic                   res_valid;
  logic [COUNT_WIDTH-1:0] sent_cnt;
  logic [COUNT_WIDTH-1:0] recv_cnt;

  phtc_front #(.WAYS(WAYS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .src_addr(src_addr), .dst_addr(dst_addr), .frame_length(frame_length),
    .slot_index(slot_index), .hold(clearing), .q_valid(q_valid), .q_item(q_item),
    .q_pop(q_pop)
  );

  phtc_back #(.WAYS(WAYS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .clearing(clearing), .res_valid(res_valid), .pop(pop),
    .entry_valid(entry_valid), .entry_addr(entry_addr), .sent_cnt(sent_cnt),
    .recv_cnt(recv_cnt), .src_dropped(src_dropped), .dst_dropped(dst_dropped)
  );

  assign empty = !res_valid;
  assign sent_bytes = 64'(sent_cnt);
  assign received_bytes = 64'(recv_cnt);

  a_read_no_drop: assert property (@(posedge clk) disable iff (rst)
    (!empty && entry_valid) |-> (!src_dropped && !dst_dropped))
    else $error("read result carries a drop flag");

  a_acct_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !entry_valid) |-> (entry_addr == 32'd0 && sent_bytes == 64'd0
                                  && received_bytes == 64'd0))
    else $error("non-entry result carries data");

  a_clear_hold: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (full && !q_pop))
    else $error("item taken during clearing pass");
endmodule

@@ sim/phtc_traffic_checker.sv @@
// Checker: predicts per-host byte counts and drop flags, compares every popped result.
`timescale 1ns / 1ps
module phtc_traffic_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        operation,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] frame_length,
  input  logic [9:0]  slot_index,
  input  logic        empty,
  input  logic        pop,
  input  logic        entry_valid,
  input  logic [31:0] entry_addr,
  input  logic [63:0] sent_bytes,
  input  logic [63:0] received_bytes,
  input  logic        src_dropped,
  input  logic        dst_dropped,
  output int          errors,
  output int          pending
);
  localparam int WAYS = phtc_pkg::WAYS_DEFAULT;
  localparam int SLOTS = phtc_pkg::BUCKETS * WAYS;

  typedef struct {
    logic        valid;
    logic [31:0] addr;
    logic [63:0] sent;
    logic [63:0] rcvd;
    logic        src_drop;
    logic        dst_drop;
  } traffic_result_t;

  logic        host_valid [SLOTS];
  logic [31:0] host_addr [SLOTS];
  logic [63:0] host_sent [SLOTS];
  logic [63:0] host_rcvd [SLOTS];
  traffic_result_t expected_results[$];

  function automatic logic [63:0] sat_add(logic [63:0] cur, logic [15:0] len);
    logic [64:0] sum;
    sum = {1'b0, cur} + len;
    return sum[64] ? '1 : sum[63:0];
  endfunction

  // slot of host, allocated in the lowest free way if absent; -1 if bucket full
  function automatic int claim_slot(logic [31:0] host);
    int base;
    int free_slot;
    base = host[31:24] * WAYS;
    free_slot = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (host_valid[base + w]) begin
        if (host_addr[base + w] == host) return base + w;
      end else if (free_slot < 0) begin
        free_slot = base + w;
      end
    end
    if (free_slot >= 0) begin
      host_valid[free_slot] = 1'b1;
      host_addr[free_slot] = host;
      host_sent[free_slot] = '0;
      host_rcvd[free_slot] = '0;
    end
    return free_slot;
  endfunction

  task automatic compare(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", field, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    for (int i = 0; i < SLOTS; i++) host_valid[i] = 1'b0;
  end

  always @(posedge clk) begin
    traffic_result_t r;
    traffic_result_t got;
    int s;
    if (!rst) begin
      if (push && !full) begin
        r = '{1'b0, 32'h0, 64'h0, 64'h0, 1'b0, 1'b0};
        if (operation == phtc_pkg::OP_ACCOUNT) begin
          s = claim_slot(src_addr);
          if (s < 0) r.src_drop = 1'b1;
          else host_sent[s] = sat_add(host_sent[s], frame_length);
          s = claim_slot(dst_addr);
          if (s < 0) r.dst_drop = 1'b1;
          else host_rcvd[s] = sat_add(host_rcvd[s], frame_length);
        end else if (slot_index < SLOTS && host_valid[slot_index]) begin
          r.valid = 1'b1;
          r.addr = host_addr[slot_index];
          r.sent = host_sent[slot_index];
          r.rcvd = host_rcvd[slot_index];
        end
        expected_results.push_back(r);
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          got = expected_results.pop_front();
          compare("entry_valid", got.valid, entry_valid);
          compare("entry_addr", got.addr, entry_addr);
          compare("sent_bytes", got.sent, sent_bytes);
          compare("received_bytes", got.rcvd, received_bytes);
          compare("src_dropped", got.src_drop, src_dropped);
          compare("dst_dropped", got.dst_drop, dst_dropped);
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

@@ sim/tb_per_host_traffic_counter_table.sv @@
// Testbench top: stimulus, result draining and verdict for the host traffic table.
`timescale 1ns / 1ps
module tb_per_host_traffic_counter_table;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        operation = phtc_pkg::OP_ACCOUNT;
  logic [31:0] src_addr = '0;
  logic [31:0] dst_addr = '0;
  logic [15:0] frame_length = '0;
  logic [9:0]  slot_index = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        entry_valid;
  logic [31:0] entry_addr;
  logic [63:0] sent_bytes;
  logic [63:0] received_bytes;
  logic        src_dropped;
  logic        dst_dropped;
  int          errors;
  int          pending;
  logic        hold_req = 1'b0;
  logic [31:0] host_pool [24];
  logic [7:0]  pool_bucket [4];

  per_host_traffic_counter_table uut (.*);
  phtc_traffic_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(logic op, logic [31:0] src, logic [31:0] dst, logic [15:0] len,
                      logic [9:0] idx);
    int g;
    operation <= op;
    src_addr <= src;
    dst_addr <= dst;
    frame_length <= len;
    slot_index <= idx;
    push <= 1'b1;
    do @(posedge clk); while (full);
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_host();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return host_pool[$urandom_range(0, 23)];
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return $urandom();
    endcase
  endfunction

  // receiver: random pops, and one long hold-off on request
  initial begin
    int g;
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        for (int c = 0; c < 300; c++) @(posedge clk);
        hold_req = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [9:0] idx;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed
    send(phtc_pkg::OP_READ, 0, 0, 0, 10'd0);
    send(phtc_pkg::OP_READ, 0, 0, 0, 10'd1023);
    send(phtc_pkg::OP_ACCOUNT, 32'h00000000, 32'hFFFFFFFF, 16'hFFFF, 0);
    send(phtc_pkg::OP_ACCOUNT, 32'h0A000001, 32'h0A000001, 16'h0000, 0);
    send(phtc_pkg::OP_ACCOUNT, 32'h0A000001, 32'h0A000001, 16'h1234, 0);
    for (int i = 2; i <= 6; i++)
      send(phtc_pkg::OP_ACCOUNT, 32'h0A000000 | i, 32'hFFFFFF00 | i, 16'h0100, 0);
    send(phtc_pkg::OP_ACCOUNT, 32'h0A0000AA, 32'hFFFFFFAA, 16'hFFFF, 0);
    send(phtc_pkg::OP_ACCOUNT, 32'h0A000003, 32'h0A0000BB, 16'h0001, 0);
    for (int w = 0; w < 4; w++) send(phtc_pkg::OP_READ, 0, 0, 0, 10'h028 | w);
    for (int w = 0; w < 4; w++) send(phtc_pkg::OP_READ, 0, 0, 0, 10'h3FC | w);
    send(phtc_pkg::OP_READ, 0, 0, 0, 10'd0);
    send(phtc_pkg::OP_READ, 0, 0, 0, 10'h155);
    push <= 1'b0;
    @(negedge clk);
    wait (pending == 0);

    for (int b = 0; b < 4; b++) pool_bucket[b] = $urandom();
    for (int i = 0; i < 24; i++) host_pool[i] = {pool_bucket[i % 4], 24'($urandom())};

    for (int n = 0; n < 400; n++) begin
      if (n == 150) hold_req = 1'b1;
      if (n == 300) begin
        push <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      if ($urandom_range(0, 9) < 7) begin
        send(phtc_pkg::OP_ACCOUNT, pick_host(), pick_host(), pick_len(), 0);
      end else begin
        if ($urandom_range(0, 4) == 0) idx = $urandom();
        else idx = {pool_bucket[$urandom_range(0, 3)], 2'($urandom())};
        send(phtc_pkg::OP_READ, $urandom(), $urandom(), $urandom(), idx);
      end
    end
    push <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("tb_per_host_traffic_counter_table: clean");
    else
      $display("tb_per_host_traffic_counter_table: errors");
    $finish;
  end

  initial begin
    #6000000;
    $display("tb_per_host_traffic_counter_table: errors");
    $finish;
  end
endmodule
